### src/breakpoint_line_table_fill_unit_defines.svh
// ----------------------------------------------------------------------------
// Breakpoint line table fill unit: assertion macros
// Concurrent checks on the rising clock edge; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_LINE_TABLE_FILL_UNIT_DEFINES_SVH
`define BREAKPOINT_LINE_TABLE_FILL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check a property outside reset
`define BLFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every edge, reset included
`define BLFT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLFT_ASSERT(label, prop, msg)
`define BLFT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### src/blft_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint line table fill unit: shared package
// Widths, codes and small types shared by the table fill unit and its divider.
// ----------------------------------------------------------------------------
package blft_pkg;

  localparam int LEVEL_WIDTH         = 24;
  localparam int EXTRA_FRACTION_BITS = 16;
  localparam int POS_WIDTH           = 16;
  localparam int ACC_WIDTH           = LEVEL_WIDTH + EXTRA_FRACTION_BITS;
  // step needs one more bit than the accumulator: a two-entry segment
  // carries the full difference range
  localparam int STEP_WIDTH          = ACC_WIDTH + 1;
  localparam int DIFF_WIDTH          = LEVEL_WIDTH + 1;
  localparam int DIV_WIDTH           = STEP_WIDTH;
  localparam int DIV_CNT_WIDTH       = $clog2(DIV_WIDTH + 1);

  localparam int APB_ADDR_WIDTH      = 3;
  localparam int APB_DATA_WIDTH      = 32;

  localparam logic [POS_WIDTH-1:0] TABLE_SIZE_RESET = 16'd4096;

  // register index (word address)
  localparam logic REG_TABLE_SIZE = 1'b0;

  // item kinds
  localparam logic KIND_BREAKPOINT = 1'b0;
  localparam logic KIND_TICK       = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_STOPPED = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [1:0] STATUS_PENDING = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/blft_div.sv
// ----------------------------------------------------------------------------
// Breakpoint line table fill unit: serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "breakpoint_line_table_fill_unit_defines.svh"

module blft_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [blft_pkg::DIV_WIDTH-1:0]     dividend,
  input  logic [blft_pkg::POS_WIDTH-1:0]     divisor,
  output logic [blft_pkg::DIV_WIDTH-1:0]     quotient,
  output blft_pkg::div_stat_t                stat
);

  logic                                  busy;
  logic                                  done;
  logic [blft_pkg::DIV_CNT_WIDTH-1:0]    cnt;
  logic [blft_pkg::DIV_WIDTH-1:0]        shreg;
  logic [blft_pkg::POS_WIDTH-1:0]        rem;
  logic [blft_pkg::POS_WIDTH-1:0]        dvsr;
  logic [blft_pkg::POS_WIDTH+1:0]        trial;

  // shift next dividend bit into the remainder, try to subtract
  assign trial = {1'b0, rem, shreg[blft_pkg::DIV_WIDTH-1]} - {2'b00, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= blft_pkg::DIV_CNT_WIDTH'(blft_pkg::DIV_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == blft_pkg::DIV_CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvsr  <= divisor;
    end else if (busy) begin
      if (!trial[blft_pkg::POS_WIDTH+1]) begin
        rem   <= trial[blft_pkg::POS_WIDTH-1:0];
        shreg <= {shreg[blft_pkg::DIV_WIDTH-2:0], 1'b1};
      end else begin
        rem   <= {rem[blft_pkg::POS_WIDTH-2:0], shreg[blft_pkg::DIV_WIDTH-1]};
        shreg <= {shreg[blft_pkg::DIV_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = shreg;
  assign stat.busy = busy;
  assign stat.done = done;

  `BLFT_ASSERT(a_div_start_idle, start |-> !busy, "divider started while busy")
  `BLFT_ASSERT_ALWAYS(a_div_done_not_busy, done |-> !busy, "divider done while busy")
  `BLFT_ASSERT(a_div_busy_from_start, $rose(busy) |-> $past(start), "divider busy without start")

endmodule

### src/breakpoint_line_table_fill_unit.sv
// ----------------------------------------------------------------------------
// Breakpoint line table fill unit
// Builds a piecewise-linear table from a stream of (x, y) breakpoints and
// hands out one table entry per tick word.
// ----------------------------------------------------------------------------
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid/in_ready, kind, x_pos, y_value,  | into block
//          | last_point                               |
//  out     | out_valid/out_ready, table_value,        | out of block
//          | table_index, status                      |
//  apb     | psel, penable, pwrite, paddr, pwdata,    | config
//          | prdata, pready                           |
//
//  Ticks stream at one per cycle while out drains and the divider is idle.
//  A breakpoint that opens a segment spanning more than one position (even one
//  cut short by table_size) runs the serial divider for the step: input
//  stalls after it until the divider is done.
//  Every other breakpoint leaves the divider idle, like a tick.
//  The result register holds a word until taken; input stalls only when the
//  result register is full and not draining, or the divider runs.
//  Synchronous reset clears all control state; table_size returns to 4096.
// ----------------------------------------------------------------------------
`include "breakpoint_line_table_fill_unit_defines.svh"

module breakpoint_line_table_fill_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  // input channel
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     kind,
  input  logic [blft_pkg::POS_WIDTH-1:0]           x_pos,
  input  logic signed [blft_pkg::LEVEL_WIDTH-1:0]  y_value,
  input  logic                                     last_point,
  // output channel
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [blft_pkg::LEVEL_WIDTH-1:0]  table_value,
  output logic [blft_pkg::POS_WIDTH-1:0]           table_index,
  output logic [1:0]                               status,
  // configuration port
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [blft_pkg::APB_ADDR_WIDTH-1:0]      paddr,
  input  logic [blft_pkg::APB_DATA_WIDTH-1:0]      pwdata,
  output logic [blft_pkg::APB_DATA_WIDTH-1:0]      prdata,
  output logic                                     pready
);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state;

  // configuration
  logic [blft_pkg::POS_WIDTH-1:0] table_size;

  // generator state
  logic [blft_pkg::POS_WIDTH-1:0]    prev_position;
  logic [blft_pkg::LEVEL_WIDTH-1:0]  prev_level;
  logic [blft_pkg::ACC_WIDTH-1:0]    level_accumulator;
  logic [blft_pkg::STEP_WIDTH-1:0]   level_step;
  logic [blft_pkg::POS_WIDTH-1:0]    entries_left;
  logic [blft_pkg::POS_WIDTH-1:0]    write_position;
  logic                              have_first_point;
  logic                              stopped_flag;
  logic                              constant_fill_mode;
  logic                              step_negative;

  // datapath
  logic                              in_fire;
  logic                              has_room;
  logic                              emit_const;
  logic                              emit_segment;
  logic [blft_pkg::POS_WIDTH-1:0]    seglen;
  logic [blft_pkg::POS_WIDTH-1:0]    room;
  logic [blft_pkg::POS_WIDTH-1:0]    seg_entries;
  logic [blft_pkg::DIFF_WIDTH-1:0]   diff;
  logic [blft_pkg::DIFF_WIDTH-1:0]   diff_mag;
  logic [blft_pkg::STEP_WIDTH-1:0]   acc_sum;
  logic                              div_start;
  logic [blft_pkg::DIV_WIDTH-1:0]    div_dividend;
  logic [blft_pkg::DIV_WIDTH-1:0]    div_quotient;
  blft_pkg::div_stat_t               div_stat;

  logic [blft_pkg::LEVEL_WIDTH-1:0]  res_value;
  logic [1:0]                        res_status;
  logic                              bp_opens;

  // --------------------------------------------------------------------------
  // configuration port: single register, zero wait states
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= blft_pkg::TABLE_SIZE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == blft_pkg::REG_TABLE_SIZE) begin
      table_size <= pwdata[blft_pkg::POS_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == blft_pkg::REG_TABLE_SIZE) begin
      prdata = blft_pkg::APB_DATA_WIDTH'(table_size);
    end
  end

  // --------------------------------------------------------------------------
  // accept: take a word when the sequencer is idle and the result register
  // is free or draining this cycle
  // --------------------------------------------------------------------------
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  // tick decode
  assign has_room     = write_position < table_size;
  assign emit_const   = has_room && constant_fill_mode;
  assign emit_segment = has_room && !constant_fill_mode && (entries_left != '0);

  // segment setup for a breakpoint that closes a segment
  assign seglen      = x_pos - prev_position;
  assign room        = has_room ? (table_size - write_position) : '0;
  assign seg_entries = (seglen < room) ? seglen : room;

  // level difference is one bit wider than a level; divide its magnitude
  assign diff     = {y_value[blft_pkg::LEVEL_WIDTH-1], y_value} -
                    {prev_level[blft_pkg::LEVEL_WIDTH-1], prev_level};
  assign diff_mag = diff[blft_pkg::DIFF_WIDTH-1] ? (~diff + 1'b1) : diff;
  assign div_dividend = blft_pkg::DIV_WIDTH'(diff_mag) << blft_pkg::EXTRA_FRACTION_BITS;

  // a breakpoint that passes every guard and opens a segment
  assign bp_opens = (kind == blft_pkg::KIND_BREAKPOINT) && !stopped_flag &&
                    !constant_fill_mode && (entries_left == '0) && have_first_point &&
                    !(x_pos < prev_position);

  // start the divider only when the step is not trivially zero
  assign div_start = in_fire && bp_opens && (seglen > blft_pkg::POS_WIDTH'(1));

  // accumulator advance: sign-extend, add step, drop the guard bit
  assign acc_sum = {level_accumulator[blft_pkg::ACC_WIDTH-1], level_accumulator} + level_step;

  // result of the word at the input
  always_comb begin
    res_value  = '0;
    res_status = blft_pkg::STATUS_OK;
    if (kind == blft_pkg::KIND_TICK) begin
      if (emit_const) begin
        res_value = prev_level;
      end else if (emit_segment) begin
        // floor of the accumulator: keep the upper bits
        res_value = level_accumulator[blft_pkg::ACC_WIDTH-1 -: blft_pkg::LEVEL_WIDTH];
      end else begin
        res_status = stopped_flag ? blft_pkg::STATUS_STOPPED : blft_pkg::STATUS_EMPTY;
      end
    end else begin
      if (stopped_flag) begin
        res_status = blft_pkg::STATUS_STOPPED;
      end else if (constant_fill_mode || entries_left != '0) begin
        res_status = blft_pkg::STATUS_PENDING;
      end else if (have_first_point && x_pos < prev_position) begin
        res_status = blft_pkg::STATUS_STOPPED;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequencer and generator state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      prev_position      <= '0;
      prev_level         <= '0;
      level_accumulator  <= '0;
      level_step         <= '0;
      entries_left       <= '0;
      write_position     <= '0;
      have_first_point   <= 1'b0;
      stopped_flag       <= 1'b0;
      constant_fill_mode <= 1'b0;
      step_negative      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (kind == blft_pkg::KIND_TICK) begin
              if (emit_const) begin
                write_position <= write_position + 1'b1;
              end else if (emit_segment) begin
                write_position <= write_position + 1'b1;
                entries_left   <= entries_left - 1'b1;
                // advance only while entries remain after this one
                if (entries_left != blft_pkg::POS_WIDTH'(1)) begin
                  level_accumulator <= acc_sum[blft_pkg::ACC_WIDTH-1:0];
                end
              end
            end else if (!stopped_flag && !constant_fill_mode && entries_left == '0) begin
              if (!have_first_point) begin
                have_first_point   <= 1'b1;
                prev_position      <= x_pos;
                prev_level         <= y_value;
                constant_fill_mode <= last_point;
              end else if (x_pos < prev_position) begin
                stopped_flag <= 1'b1;
              end else begin
                // open the segment from the old start point
                level_accumulator <= blft_pkg::ACC_WIDTH'(prev_level) <<
                                     blft_pkg::EXTRA_FRACTION_BITS;
                entries_left      <= seg_entries;
                prev_position     <= x_pos;
                prev_level        <= y_value;
                level_step        <= '0;
                step_negative     <= diff[blft_pkg::DIFF_WIDTH-1];
                if (div_start) begin
                  state <= ST_DIV;
                end
              end
            end
          end
        end
        ST_DIV: begin
          // hold input until the quotient lands, then apply the sign
          if (div_stat.done) begin
            level_step <= step_negative ? (~div_quotient + 1'b1) : div_quotient;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result register: load on accept, drop when taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      table_value <= res_value;
      table_index <= write_position;
      status      <= res_status;
    end
  end

  // serial divider for the segment step
  blft_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (seglen - 1'b1),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  `BLFT_ASSERT(a_no_accept_while_dividing, div_stat.busy |-> !in_ready, "input accepted during divide")
  `BLFT_ASSERT(a_done_in_div_state, div_stat.done |-> state == ST_DIV, "divider done outside divide state")
  `BLFT_ASSERT(a_fill_no_segment, !constant_fill_mode || entries_left == '0, "fill with segment")
  `BLFT_ASSERT(a_segment_tick_counts_down, (in_fire && kind == blft_pkg::KIND_TICK && emit_segment) |=> entries_left == $past(entries_left) - 16'd1, "segment tick did not consume an entry")

endmodule

### tb/sv/line_table_checker.sv
// ----------------------------------------------------------------------------
// Line table checker
// Watches the word and config channels of the table fill unit, predicts each
// result word and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module line_table_checker
  import blft_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              kind,
  input  logic [POS_WIDTH-1:0]              x_pos,
  input  logic signed [LEVEL_WIDTH-1:0]     y_value,
  input  logic                              last_point,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [LEVEL_WIDTH-1:0]     table_value,
  input  logic [POS_WIDTH-1:0]              table_index,
  input  logic [1:0]                        status,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [APB_ADDR_WIDTH-1:0]         paddr,
  input  logic [APB_DATA_WIDTH-1:0]         pwdata,
  output int                                mismatches,
  output int                                outstanding,
  output logic [POS_WIDTH-1:0]              fill_level
);

  localparam logic [APB_ADDR_WIDTH-1:0] TABLE_SIZE_ADDR = APB_ADDR_WIDTH'(4 * REG_TABLE_SIZE);
  localparam int REPORT_LIMIT = 50;

  typedef struct packed {
    logic signed [LEVEL_WIDTH-1:0] value;
    logic [POS_WIDTH-1:0]          index;
    logic [1:0]                    status;
  } table_word_t;

  table_word_t pending_words[$];
  int          checked_words = 0;

  // predicted unit state
  logic [POS_WIDTH-1:0]          table_size;
  logic [POS_WIDTH-1:0]          start_pos;
  logic signed [LEVEL_WIDTH-1:0] start_level;
  longint                        level_acc;
  longint                        level_step;
  logic [POS_WIDTH-1:0]          seg_left;
  logic [POS_WIDTH-1:0]          fill_pos;
  logic                          have_start;
  logic                          halted;
  logic                          const_fill;

  initial mismatches = 0;
  initial outstanding = 0;
  initial fill_level = '0;

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < REPORT_LIMIT)
      $display("mismatch at result word %0d: %s got %0d expected %0d",
               checked_words, what, got, want);
    mismatches++;
  endtask

  function automatic table_word_t predict_table_word(logic k, logic [POS_WIDTH-1:0] x,
                                                     logic signed [LEVEL_WIDTH-1:0] y,
                                                     logic last);
    table_word_t  w;
    longint unsigned span;
    longint unsigned room;
    longint       diff;
    w.value  = '0;
    w.index  = fill_pos;
    w.status = STATUS_OK;
    if (k == KIND_TICK) begin
      if (fill_pos < table_size && const_fill) begin
        w.value  = start_level;
        fill_pos = fill_pos + 1'b1;
      end else if (fill_pos < table_size && seg_left != 0) begin
        w.value  = LEVEL_WIDTH'(level_acc >>> EXTRA_FRACTION_BITS);
        fill_pos = fill_pos + 1'b1;
        seg_left = seg_left - 1'b1;
        if (seg_left != 0)
          level_acc = level_acc + level_step;
      end else begin
        w.status = halted ? STATUS_STOPPED : STATUS_EMPTY;
      end
    end else if (halted) begin
      w.status = STATUS_STOPPED;
    end else if (const_fill || seg_left != 0) begin
      w.status = STATUS_PENDING;
    end else if (!have_start) begin
      have_start  = 1'b1;
      start_pos   = x;
      start_level = y;
      const_fill  = last;
    end else if (x < start_pos) begin
      halted   = 1'b1;
      w.status = STATUS_STOPPED;
    end else begin
      span = x - start_pos;
      room = (fill_pos < table_size) ? table_size - fill_pos : 0;
      diff = longint'(y) - longint'(start_level);
      level_step = 0;
      if (span > 1)
        level_step = (diff <<< EXTRA_FRACTION_BITS) / longint'(span - 1);
      level_acc   = longint'(start_level) <<< EXTRA_FRACTION_BITS;
      seg_left    = POS_WIDTH'((span < room) ? span : room);
      start_pos   = x;
      start_level = y;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    table_word_t want;
    if (rst) begin
      table_size  = TABLE_SIZE_RESET;
      start_pos   = '0;
      start_level = '0;
      level_acc   = 0;
      level_step  = 0;
      seg_left    = '0;
      fill_pos    = '0;
      have_start  = 1'b0;
      halted      = 1'b0;
      const_fill  = 1'b0;
      pending_words.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == TABLE_SIZE_ADDR)
        table_size = pwdata[POS_WIDTH-1:0];
      if (in_valid && in_ready)
        pending_words.push_back(predict_table_word(kind, x_pos, y_value, last_point));
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          report_mismatch("result word with nothing pending, status", status, 0);
        end else begin
          want = pending_words.pop_front();
          if (table_value !== want.value)
            report_mismatch("table_value", longint'(table_value), longint'(want.value));
          if (table_index !== want.index)
            report_mismatch("table_index", table_index, want.index);
          if (status !== want.status)
            report_mismatch("status", status, want.status);
        end
        checked_words++;
      end
    end
    outstanding <= pending_words.size();
    fill_level  <= fill_pos;
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Table fill unit testbench
// Drives breakpoint and tick words through the unit over several table sizes,
// with random sender gaps and receiver stalls; the checker judges every word.
// ----------------------------------------------------------------------------
module tb;
  import blft_pkg::*;

  localparam logic [APB_ADDR_WIDTH-1:0] TABLE_SIZE_ADDR = APB_ADDR_WIDTH'(4 * REG_TABLE_SIZE);
  localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_MIN = {1'b1, {(LEVEL_WIDTH-1){1'b0}}};
  localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_MAX = {1'b0, {(LEVEL_WIDTH-1){1'b1}}};
  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
  // keep random positions well below the top so the closing jump still fits
  localparam int X_CEILING   = 60000;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE} drain_mode_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          kind = KIND_TICK;
  logic [POS_WIDTH-1:0]          x_pos = '0;
  logic signed [LEVEL_WIDTH-1:0] y_value = '0;
  logic                          last_point = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [LEVEL_WIDTH-1:0] table_value;
  logic [POS_WIDTH-1:0]          table_index;
  logic [1:0]                    status;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0]     paddr = '0;
  logic [APB_DATA_WIDTH-1:0]     pwdata = '0;
  logic [APB_DATA_WIDTH-1:0]     prdata;
  logic                          pready;

  int                            mismatches;
  int                            outstanding;
  logic [POS_WIDTH-1:0]          fill_level;

  int                            cycle_count = 0;
  int                            sent_words = 0;
  int                            burst_left = 0;
  int                            cur_x = 0;
  logic signed [LEVEL_WIDTH-1:0] last_level = '0;

  drain_mode_t                   rx_mode = RX_OPEN;
  logic [7:0]                    rx_cycle = '0;
  int                            rx_hold = 0;

  breakpoint_line_table_fill_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .x_pos      (x_pos),
    .y_value    (y_value),
    .last_point (last_point),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .table_value(table_value),
    .table_index(table_index),
    .status     (status),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  line_table_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .x_pos      (x_pos),
    .y_value    (y_value),
    .last_point (last_point),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .table_value(table_value),
    .table_index(table_index),
    .status     (status),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .fill_level (fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost result word ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: pick a drain mode whenever the 8-bit cycle counter wraps; open, coin toss,
  // or long chokes broken by single ready cycles.
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (rx_cycle == 8'd0)
      rx_mode <= drain_mode_t'($urandom_range(0, 2));
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_COIN: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (rx_hold != 0) begin
          out_ready <= 1'b0;
          rx_hold   <= rx_hold - 1;
        end else begin
          out_ready <= 1'b1;
          rx_hold   <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  // Offer one word and hold it until the unit takes it. Between bursts, drop
  // valid for a random gap; some bursts start with no gap at all.
  task automatic push_word(logic k, logic [POS_WIDTH-1:0] x,
                           logic signed [LEVEL_WIDTH-1:0] y, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    kind       <= k;
    x_pos      <= x;
    y_value    <= y;
    last_point <= last;
    do @(posedge clk); while (!in_ready);
    sent_words++;
  endtask

  // Tick words carry junk in the unused fields.
  task automatic push_tick();
    push_word(KIND_TICK, POS_WIDTH'($urandom), LEVEL_WIDTH'($urandom), 1'($urandom));
  endtask

  // Drop valid, wait for every result word, then let the step divider wind down.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (2 * DIV_WIDTH) @(negedge clk);
  endtask

  task automatic write_table_size(int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TABLE_SIZE_ADDR;
    pwdata  <= APB_DATA_WIDTH'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly well-formed segments: one breakpoint, then enough ticks to drain it,
  // sometimes one extra. Mix in stray ticks and breakpoints that repeat the
  // current position, which land either on a busy segment or as a zero-length one.
  task automatic build_segments(int word_goal);
    int stop_at;
    int span;
    int ticks;
    int stray_at;
    logic signed [LEVEL_WIDTH-1:0] level;
    stop_at = sent_words + word_goal;
    while (sent_words < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0)
          push_tick();
        else
          push_word(KIND_BREAKPOINT, POS_WIDTH'(cur_x), LEVEL_WIDTH'($urandom), 1'($urandom));
      end else begin
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 48) : $urandom_range(0, 6);
        if (cur_x + span > X_CEILING)
          span = 0;
        if ($urandom_range(0, 2) == 0)
          level = last_level + LEVEL_WIDTH'(int'($urandom_range(0, 64)) - 32);
        else
          level = LEVEL_WIDTH'($urandom);
        cur_x      = cur_x + span;
        last_level = level;
        push_word(KIND_BREAKPOINT, POS_WIDTH'(cur_x), level, 1'($urandom));
        stray_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, span) : -1;
        ticks    = span + (($urandom_range(0, 4) == 0) ? 1 : 0);
        for (int i = 0; i < ticks; i++) begin
          if (i == stray_at)
            push_word(KIND_BREAKPOINT, POS_WIDTH'(cur_x), LEVEL_WIDTH'($urandom), 1'b0);
          push_tick();
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Open the table to its largest size.
    write_table_size(POS_MAX);

    // Directed opening. A first point marked last would lock the table in
    // constant fill for the rest of the run, so the first point here is unmarked.
    push_tick();                                            // nothing to emit yet
    push_word(KIND_BREAKPOINT, 16'd0, '0, 1'b0);            // start point
    push_word(KIND_BREAKPOINT, 16'd0, LEVEL_MIN, 1'b1);     // zero length, mark ignored
    push_word(KIND_BREAKPOINT, 16'd2, LEVEL_MAX, 1'b0);     // two entries, widest step
    push_word(KIND_BREAKPOINT, 16'd3, '0, 1'b0);            // busy segment: pending
    push_tick();
    push_tick();
    push_tick();                                            // drained: empty
    push_word(KIND_BREAKPOINT, 16'd3, LEVEL_MIN, 1'b1);     // one entry, zero step
    push_tick();
    push_word(KIND_BREAKPOINT, 16'd7, LEVEL_MAX, 1'b0);     // rising, four entries
    repeat (4) push_tick();
    push_word(KIND_BREAKPOINT, 16'd10, -24'sd1, 1'b0);      // falling, three entries
    repeat (3) push_tick();
    push_word(KIND_BREAKPOINT, 16'd10, 24'sd1, 1'b0);       // zero length
    push_word(KIND_BREAKPOINT, 16'd12, -24'sd2, 1'b0);      // small negative step
    repeat (2) push_tick();
    cur_x      = 12;
    last_level = -24'sd2;

    build_segments(700);

    // Hold off until every result is back, then leave only a little room so
    // segments get cut and later ones open no entries at all.
    settle();
    write_table_size(int'(fill_level) + $urandom_range(20, 80));
    build_segments(350);

    // One-entry table: everything already written lies beyond it.
    settle();
    write_table_size(1);
    build_segments(60);

    settle();
    write_table_size($urandom_range(int'(fill_level) + 1000, X_CEILING));
    build_segments(700);

    // Close: jump to the last position with five entries of room, then stop
    // the list with a decreasing position and poke the halted unit.
    settle();
    write_table_size(int'(fill_level) + 5);
    push_word(KIND_BREAKPOINT, POS_MAX, LEVEL_MAX, 1'b1);
    repeat (7) push_tick();
    push_word(KIND_BREAKPOINT, POS_MAX, LEVEL_MIN, 1'b0);
    push_word(KIND_BREAKPOINT, POS_WIDTH'(cur_x), '0, 1'b0);
    repeat (8) begin
      push_word(KIND_BREAKPOINT, POS_WIDTH'($urandom), LEVEL_WIDTH'($urandom), 1'($urandom));
      push_tick();
    end

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/blft_pkg.sv
src/blft_div.sv
src/breakpoint_line_table_fill_unit.sv
tb/sv/line_table_checker.sv
tb/sv/tb.sv
